// ===== hw/rtl/tspe_pkg.sv =====
// Shared types and constants for the trading signal and profit engine.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
package tspe_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_WINDOW    = 3'd1;
  localparam logic [2:0] REG_THRESHOLD = 3'd2;
  localparam logic [2:0] REG_ORDER     = 3'd3;
  localparam logic [2:0] REG_SPREAD    = 3'd4;
  localparam logic [2:0] REG_SKEW      = 3'd5;
  localparam logic [2:0] REG_MAX_INV   = 3'd6;

  // Strategy codes
  localparam logic [1:0] MODE_MOMENTUM  = 2'd0;
  localparam logic [1:0] MODE_MEAN_REV  = 2'd1;
  localparam logic [1:0] MODE_IMBALANCE = 2'd2;
  localparam logic [1:0] MODE_MKT_MAKE  = 2'd3;

  // Trade signal codes (2-bit signed)
  localparam logic [1:0] SIG_NONE = 2'b00;
  localparam logic [1:0] SIG_BUY  = 2'b01;
  localparam logic [1:0] SIG_SELL = 2'b11;

  // Last datapath step of one sample
  localparam logic [3:0] LAST_STEP = 4'd13;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_CALC
  } state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  wlen;
    logic [15:0] thresh;
    logic [7:0]  qty;
    logic [15:0] spread;
    logic [2:0]  skew;
    logic [15:0] maxinv;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic       first;    // first sample of a series transfer
    logic       accept;   // regular sample transfer
    logic       rd_en;    // history read
    logic [3:0] rd_idx;   // samples back, minus one
    logic       step_en;
    logic [3:0] step;
    logic       commit;   // update state and load output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic       first_now;
    logic [3:0] win;
  } status_t;

endpackage

// ===== hw/rtl/tspe_ctrl.sv =====
// Controller of the trading signal and profit engine: sequences the history
// walk and the arithmetic steps, and owns the input and output handshakes.
// Depends on tspe_pkg.
`timescale 1ns / 1ps
module tspe_ctrl
  import tspe_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  input  status_t st,
  output cmd_t    cmd
);

  state_t     state_r, state_nxt;
  logic [3:0] k_r, k_nxt;
  logic [3:0] step_r, step_nxt;
  logic       oval_r, oval_nxt;
  logic       out_free;

  assign out_free   = !oval_r || out_tready;
  assign out_tvalid = oval_r;
  assign in_tready  = (state_r == ST_IDLE);

  // Next state
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && !st.first_now) begin
          state_nxt = ST_WALK;
          k_nxt     = '0;
        end
      end
      ST_WALK: begin
        if (k_r < st.win) begin
          k_nxt = k_r + 4'd1;
        end else begin
          state_nxt = ST_CALC;
          step_nxt  = '0;
        end
      end
      ST_CALC: begin
        if (step_r == LAST_STEP) begin
          if (out_free) state_nxt = ST_IDLE;
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd        = '0;
    cmd.rd_idx = k_r;
    cmd.step   = step_r;
    oval_nxt   = oval_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        cmd.first  = in_tvalid && st.first_now;
        cmd.accept = in_tvalid && !st.first_now;
      end
      ST_WALK: begin
        cmd.rd_en = (k_r < st.win);
      end
      ST_CALC: begin
        cmd.step_en = 1'b1;
        if (step_r == LAST_STEP && out_free) begin
          cmd.commit = 1'b1;
          oval_nxt   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
      step_r  <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      step_r  <= step_nxt;
      oval_r  <= oval_nxt;
    end
  end

endmodule

// ===== hw/rtl/tspe_dp.sv =====
// Datapath of the trading signal and profit engine: price history memory,
// window accumulators, signal decision, position and profit arithmetic.
// Depends on tspe_pkg; driven by tspe_ctrl.
`timescale 1ns / 1ps
module tspe_dp
  import tspe_pkg::*;
#(
  parameter int HISTORY_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  cfg_t           cfg,
  input  logic           in_series_start,
  input  logic [15:0]    in_price,
  input  cmd_t           cmd,
  output status_t        st,
  output logic [1:0]     out_trade_signal,
  output logic [31:0]    out_inventory,
  output logic [47:0]    out_pnl_cents,
  output logic [46:0]    out_drawdown_cents,
  output logic [46:0]    out_max_drawdown_cents,
  output logic [31:0]    out_trade_count,
  output logic [31:0]    out_traded_volume,
  output logic [31:0]    out_exposure_ticks
);

  localparam int PW = (HISTORY_DEPTH > 2) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int AW = PW + 1;
  localparam logic signed [49:0] C50_MAX = 50'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [49:0] C50_MIN = -50'sh0_8000_0000_0000;
  localparam logic signed [57:0] C58_MAX = 58'sh7FFF_FFFF_FFFF;
  localparam logic signed [57:0] C58_MIN = -58'sh8000_0000_0000;

  // History memory, circular, ptr_r is the next write slot
  logic [15:0]   hist_mem [HISTORY_DEPTH];
  logic [15:0]   mem_q;
  logic [PW-1:0] ptr_r, ptr_nxt;
  logic [AW-1:0] addr_tmp;
  logic [PW-1:0] rd_addr;
  logic          wr_en;
  logic [15:0]   wr_data;

  // Architectural state
  logic [4:0]         samples_r;
  logic signed [31:0] held_r;
  logic signed [47:0] cash_r;
  logic signed [47:0] peak_r;
  logic [46:0]        worst_r;
  logic [31:0]        trades_r, volume_r, expo_r;

  // Per-sample working registers
  logic [15:0]        p_r;
  logic [3:0]         w_r;
  logic               rdv_r;
  logic [3:0]         rdi_r;
  logic [19:0]        s_r;
  logic [35:0]        sq_r;
  logic signed [4:0]  bal_r;
  logic [15:0]        cur_r, prev0_r, last_r;
  logic [39:0]        ss_r, q_r;
  logic signed [21:0] dv_r;
  logic [20:0]        dm_r;
  logic [41:0]        dm2_r;
  logic               conda_r;
  logic [31:0]        tt_r;
  logic [43:0]        rm_r;
  logic [45:0]        lhs_r;
  logic [63:0]        rl_r;
  logic [43:0]        rh_r;
  logic [1:0]         sig_r;
  logic [30:0]        gross_r;
  logic signed [48:0] ip_r;
  logic signed [55:0] ip100_r;
  logic signed [47:0] pnl_r;

  logic [3:0]  w_eff;
  logic [14:0] qty100;

  // Effective window from the register
  always_comb begin
    w_eff = (cfg.wlen == 4'd0) ? 4'd1 : cfg.wlen;
    if (32'(w_eff) > HISTORY_DEPTH) w_eff = 4'(HISTORY_DEPTH);
  end

  assign st.first_now = in_series_start || (samples_r == 5'd0);
  assign st.win       = w_r;
  assign qty100       = 15'({cfg.qty, 6'b0}) + 15'({cfg.qty, 5'b0}) + 15'({cfg.qty, 2'b0});

  // Read address: ptr - 1 - idx, modulo depth
  always_comb begin
    addr_tmp = AW'(ptr_r) + AW'(HISTORY_DEPTH - 1) - AW'(cmd.rd_idx);
    if (addr_tmp >= AW'(HISTORY_DEPTH)) addr_tmp = addr_tmp - AW'(HISTORY_DEPTH);
    rd_addr = addr_tmp[PW-1:0];
  end

  assign wr_en   = cmd.first || cmd.commit;
  assign wr_data = cmd.first ? in_price : p_r;
  assign ptr_nxt = (ptr_r == PW'(HISTORY_DEPTH - 1)) ? '0 : ptr_r + PW'(1);

  // History memory port
  always_ff @(posedge clk) begin
    if (wr_en) hist_mem[ptr_r] <= wr_data;
    mem_q <= hist_mem[rd_addr];
  end

  // Decision terms
  logic signed [16:0] dmom;
  logic signed [24:0] dm256, t25;
  logic [75:0]        rhs76, lhs76;
  logic               big;
  logic [19:0]        tw;
  logic signed [21:0] b256, tw22;
  logic signed [32:0] absinv;
  logic [15:0]        mv;
  logic signed [4:0]  mm_base, mm_adj;
  logic               enough;
  logic [1:0]         sig_nxt;

  always_comb begin
    enough  = samples_r >= {1'b0, w_r};
    dmom    = $signed({1'b0, p_r}) - $signed({1'b0, last_r});
    dm256   = {dmom, 8'b0};
    t25     = $signed({9'b0, cfg.thresh});
    rhs76   = {12'b0, rl_r} + {rh_r, 32'b0};
    lhs76   = {14'b0, lhs_r, 16'b0};
    big     = lhs76 > rhs76;
    tw      = 20'(cfg.thresh) * 20'(w_r);
    b256    = 22'(signed'({bal_r, 8'b0}));
    tw22    = $signed({2'b0, tw});
    absinv  = held_r[31] ? -33'(held_r) : 33'(held_r);
    mv      = (p_r >= prev0_r) ? p_r - prev0_r : prev0_r - p_r;
    mm_base = (p_r > prev0_r) ? -5'sd1 : 5'sd1;
    mm_adj  = mm_base;
    if (held_r > 0) mm_adj = mm_base - $signed({2'b0, cfg.skew});
    else if (held_r < 0) mm_adj = mm_base + $signed({2'b0, cfg.skew});
    sig_nxt = SIG_NONE;
    case (cfg.mode)
      MODE_MOMENTUM: begin
        if (enough) begin
          if (dm256 > t25) sig_nxt = SIG_BUY;
          else if (dm256 < -t25) sig_nxt = SIG_SELL;
        end
      end
      MODE_MEAN_REV: begin
        if (enough && dv_r != 0 && big) sig_nxt = (dv_r > 0) ? SIG_SELL : SIG_BUY;
      end
      MODE_IMBALANCE: begin
        if (enough) begin
          if (b256 > tw22) sig_nxt = SIG_BUY;
          else if (b256 < -tw22) sig_nxt = SIG_SELL;
        end
      end
      MODE_MKT_MAKE: begin
        if (absinv < $signed({17'b0, cfg.maxinv}) && {mv, 8'b0} >= {8'b0, cfg.spread}) begin
          if (mm_adj > 0) sig_nxt = SIG_BUY;
          else if (mm_adj < 0) sig_nxt = SIG_SELL;
        end
      end
      default: sig_nxt = SIG_NONE;
    endcase
  end

  // Position update terms
  logic signed [32:0] inv33;
  logic signed [49:0] cash50;
  logic [32:0]        vol33;
  logic signed [57:0] pnl58;
  logic signed [47:0] peak_n;
  logic signed [48:0] dd49;
  logic [46:0]        dd47;

  always_comb begin
    inv33  = (sig_r == SIG_BUY) ? 33'(held_r) + 33'(cfg.qty) : 33'(held_r) - 33'(cfg.qty);
    cash50 = (sig_r == SIG_BUY) ? 50'(cash_r) - 50'(gross_r) : 50'(cash_r) + 50'(gross_r);
    cash50 = cash50 - 50'({cfg.qty, 1'b0}) - 50'(cfg.qty);
    vol33  = 33'(volume_r) + 33'(cfg.qty);
    pnl58  = 58'(cash_r) + 58'(ip100_r);
    peak_n = (pnl_r > peak_r) ? pnl_r : peak_r;
    dd49   = 49'(peak_n) - 49'(pnl_r);
    dd47   = dd49[48:47] != 2'b00 ? {47{1'b1}} : dd49[46:0];
  end

  // Sequenced datapath
  always_ff @(posedge clk) begin
    rdv_r <= cmd.rd_en;
    rdi_r <= cmd.rd_idx;
    if (cmd.accept) begin
      p_r   <= in_price;
      w_r   <= w_eff;
      s_r   <= '0;
      sq_r  <= '0;
      bal_r <= '0;
      cur_r <= in_price;
    end
    // window walk, one entry per cycle
    if (rdv_r) begin
      s_r    <= s_r + 20'(mem_q);
      sq_r   <= sq_r + 36'(mem_q) * 36'(mem_q);
      bal_r  <= (cur_r >= mem_q) ? bal_r + 5'sd1 : bal_r - 5'sd1;
      cur_r  <= mem_q;
      last_r <= mem_q;
      if (rdi_r == 4'd0) prev0_r <= mem_q;
    end
    if (cmd.step_en) begin
      case (cmd.step)
        4'd0: begin
          ss_r <= 40'(s_r) * 40'(s_r);
          dv_r <= $signed(22'(p_r) * 22'(w_r)) - $signed(22'(s_r));
        end
        4'd1: begin
          q_r  <= 40'(sq_r) * 40'(w_r) - ss_r;
          dm_r <= dv_r[21] ? 21'(-dv_r) : 21'(dv_r);
        end
        4'd2: begin
          dm2_r   <= 42'(dm_r) * 42'(dm_r);
          conda_r <= (w_r >= 4'd2) && (q_r >= 40'(8'(w_r) * 8'(w_r - 4'd1)));
        end
        4'd3: begin
          tt_r <= 32'(cfg.thresh) * 32'(cfg.thresh);
          rm_r <= conda_r ? 44'(q_r) * 44'(w_r) : 44'(8'(w_r) * 8'(w_r));
        end
        4'd4: lhs_r <= 46'(dm2_r) * 46'(conda_r ? w_r - 4'd1 : 4'd1);
        4'd5: rl_r <= 64'(tt_r) * 64'(rm_r[31:0]);
        4'd6: rh_r <= 44'(tt_r) * 44'(rm_r[43:32]);
        4'd7: sig_r <= sig_nxt;
        4'd8: gross_r <= 31'(p_r) * 31'(qty100);
        4'd10: ip_r <= held_r * $signed({1'b0, p_r});
        4'd11: ip100_r <= (56'(ip_r) <<< 6) + (56'(ip_r) <<< 5) + (56'(ip_r) <<< 2);
        4'd12: begin
          if (pnl58 > C58_MAX) pnl_r <= C58_MAX[47:0];
          else if (pnl58 < C58_MIN) pnl_r <= C58_MIN[47:0];
          else pnl_r <= pnl58[47:0];
        end
        default: ;
      endcase
    end
    if (cmd.commit) begin
      out_trade_signal       <= sig_r;
      out_inventory          <= held_r;
      out_pnl_cents          <= pnl_r;
      out_drawdown_cents     <= dd47;
      out_max_drawdown_cents <= (dd47 > worst_r) ? dd47 : worst_r;
      out_trade_count        <= trades_r;
      out_traded_volume      <= volume_r;
      out_exposure_ticks     <= (held_r != 0 && expo_r != '1) ? expo_r + 32'd1 : expo_r;
    end
  end

  // Series state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r     <= '0;
      samples_r <= '0;
      held_r    <= '0;
      cash_r    <= '0;
      peak_r    <= '0;
      worst_r   <= '0;
      trades_r  <= '0;
      volume_r  <= '0;
      expo_r    <= '0;
    end else if (cmd.first) begin
      ptr_r     <= ptr_nxt;
      samples_r <= 5'd1;
      held_r    <= '0;
      cash_r    <= '0;
      peak_r    <= '0;
      worst_r   <= '0;
      trades_r  <= '0;
      volume_r  <= '0;
      expo_r    <= '0;
    end else begin
      // trade applied
      if (cmd.step_en && cmd.step == 4'd9 && sig_r != SIG_NONE) begin
        if (inv33 > 33'sh0_7FFF_FFFF) held_r <= 32'sh7FFF_FFFF;
        else if (inv33 < -33'sh0_8000_0000) held_r <= 32'sh8000_0000;
        else held_r <= inv33[31:0];
        if (cash50 > C50_MAX) cash_r <= C50_MAX[47:0];
        else if (cash50 < C50_MIN) cash_r <= C50_MIN[47:0];
        else cash_r <= cash50[47:0];
        if (trades_r != '1) trades_r <= trades_r + 32'd1;
        volume_r <= vol33[32] ? '1 : vol33[31:0];
      end
      if (cmd.commit) begin
        ptr_r   <= ptr_nxt;
        peak_r  <= peak_n;
        worst_r <= (dd47 > worst_r) ? dd47 : worst_r;
        if (held_r != 0 && expo_r != '1) expo_r <= expo_r + 32'd1;
        if (samples_r != 5'd31) samples_r <= samples_r + 5'd1;
      end
    end
  end

endmodule

// ===== hw/rtl/trading_signal_pnl_engine.sv =====
// Top level of the trading signal and profit engine: configuration registers,
// controller and datapath. Depends on tspe_pkg, tspe_ctrl and tspe_dp.
//
// Usage: price samples enter on the in_ stream, one per transfer. Each
// sample after the first of a series returns one result transfer on the
// out_ stream; a sample with series_start set, or the first after reset,
// clears the series state and returns nothing. Registers are written on the
// cfg_ channel (always ready); the user must write them only while no
// sample is in flight, as the block itself does not enforce this.
// Flow: a regular sample's transfer starts a walk over the last W history
// entries, one memory entry per cycle through the registered memory read;
// the arithmetic then runs 14 steps on a shared set of registers. W is the
// effective window (1..15). One sample is in work at a time, so a regular
// sample is taken only after the previous one has left its last step; a
// first sample leaves the block ready again at once.
// A finished result sits in the output register, and the next sample is
// taken meanwhile; if out_tready stays low, that sample waits at its last
// step until the register frees.
// Reset: synchronous active-low rst_n restores the register defaults and
// clears the series state; the history memory is not cleared.
`timescale 1ns / 1ps
module trading_signal_pnl_engine
  import tspe_pkg::*;
#(
  parameter int HISTORY_DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [23:0]  in_tdata,   // [0] series_start, [16:1] price, [23:17] zero
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [271:0] out_tdata,  // [1:0] trade_signal, [33:2] inventory,
                                   // [81:34] pnl_cents, [128:82] drawdown_cents,
                                   // [175:129] max_drawdown_cents,
                                   // [207:176] trade_count,
                                   // [239:208] traded_volume,
                                   // [271:240] exposure_ticks
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  cfg_t    cfg_r, cfg_nxt;
  cmd_t    cmd;
  status_t st;

  logic [1:0]  o_sig;
  logic [31:0] o_inv;
  logic [47:0] o_pnl;
  logic [46:0] o_dd, o_mdd;
  logic [31:0] o_trades, o_vol, o_expo;

  assign cfg_ready = 1'b1;

  // Register file writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:      cfg_nxt.mode   = cfg_data[1:0];
        REG_WINDOW:    cfg_nxt.wlen   = cfg_data[3:0];
        REG_THRESHOLD: cfg_nxt.thresh = cfg_data;
        REG_ORDER:     cfg_nxt.qty    = cfg_data[7:0];
        REG_SPREAD:    cfg_nxt.spread = cfg_data;
        REG_SKEW:      cfg_nxt.skew   = cfg_data[2:0];
        REG_MAX_INV:   cfg_nxt.maxinv = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode   <= MODE_MOMENTUM;
      cfg_r.wlen   <= 4'd4;
      cfg_r.thresh <= 16'd256;
      cfg_r.qty    <= 8'd1;
      cfg_r.spread <= 16'd256;
      cfg_r.skew   <= 3'd0;
      cfg_r.maxinv <= 16'd20;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tspe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  tspe_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg                    (cfg_r),
    .in_series_start        (in_tdata[0]),
    .in_price               (in_tdata[16:1]),
    .cmd                    (cmd),
    .st                     (st),
    .out_trade_signal       (o_sig),
    .out_inventory          (o_inv),
    .out_pnl_cents          (o_pnl),
    .out_drawdown_cents     (o_dd),
    .out_max_drawdown_cents (o_mdd),
    .out_trade_count        (o_trades),
    .out_traded_volume      (o_vol),
    .out_exposure_ticks     (o_expo)
  );

  assign out_tdata = {o_expo, o_vol, o_trades, o_mdd, o_dd, o_pnl, o_inv, o_sig};

endmodule

// ===== hw/rtl/tspe_checker.sv =====
// Port-level checks for the trading signal and profit engine, bound to the
// top level. Depends only on the top-level ports.
`timescale 1ns / 1ps
module tspe_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [23:0]  in_tdata,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [271:0] out_tdata
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // A series start returns no result, so the block is ready again at once
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata[0] |=> in_tready)
    else $error("series start kept the block busy");

  // A new result only comes out of a sample in work
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result without a sample in work");

  // Trade signal is -1, 0 or 1
  a_sig_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'b10)
    else $error("bad trade signal code");

endmodule

bind trading_signal_pnl_engine tspe_checker u_tspe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== dv/testbench.sv =====
// Testbench for trading_signal_pnl_engine: random-walk price series under every
// strategy, checked result by result against a built-in predictor.
// Depends on tspe_pkg and the engine RTL.
`timescale 1ns / 1ps

// Tracks engine state, predicts each result and checks returned results
class pnl_scoreboard;
  // register copies
  logic [1:0]  mode;
  logic [3:0]  wlen;
  logic [15:0] thresh;
  logic [7:0]  qty;
  logic [15:0] spread;
  logic [2:0]  skew;
  logic [15:0] maxinv;
  // series state
  logic [15:0] hist[16];
  int          seen;
  longint      inv, cash, peak, worst;
  longint      trades, volume, expo;
  logic [271:0] expected_q[$];
  int          errors;
  int          results;
  int          signals[3];

  function new();
    mode = tspe_pkg::MODE_MOMENTUM; wlen = 4; thresh = 256; qty = 1;
    spread = 256; skew = 0; maxinv = 20;
    errors = 0; results = 0;
    foreach (signals[i]) signals[i] = 0;
    clear();
  endfunction

  function void clear();
    foreach (hist[i]) hist[i] = '0;
    seen = 0; inv = 0; cash = 0; peak = 0; worst = 0;
    trades = 0; volume = 0; expo = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [15:0] val);
    case (idx)
      tspe_pkg::REG_MODE:      mode   = val[1:0];
      tspe_pkg::REG_WINDOW:    wlen   = val[3:0];
      tspe_pkg::REG_THRESHOLD: thresh = val;
      tspe_pkg::REG_ORDER:     qty    = val[7:0];
      tspe_pkg::REG_SPREAD:    spread = val;
      tspe_pkg::REG_SKEW:      skew   = val[2:0];
      tspe_pkg::REG_MAX_INV:   maxinv = val;
      default: ;
    endcase
  endfunction

  static function longint clamp48(longint v);
    longint hi;
    hi = 64'h7FFF_FFFF_FFFF;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  static function longint sat32(longint v);
    return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
  endfunction

  // strategy decision: -1 sell, 0 none, +1 buy
  function int decide(longint p, int w);
    longint t, d, bal, cur, last, mv, absinv, sig;
    longint unsigned s, sq, q, dm, tt, ww, x;
    logic [127:0] lhs, rhs, m1, m2;
    t = thresh;
    ww = w;
    case (mode)
      tspe_pkg::MODE_MOMENTUM: begin
        if (seen < w) return 0;
        d = (p - longint'(hist[w-1])) * 256;
        return d > t ? 1 : (d < -t ? -1 : 0);
      end
      tspe_pkg::MODE_MEAN_REV: begin
        if (seen < w) return 0;
        s = 0; sq = 0;
        for (int k = 0; k < w; k++) begin
          x = hist[k];
          s += x;
          sq += x * x;
        end
        q = ww * sq - s * s;
        d = longint'(ww * longint'(p)) - longint'(s);
        if (d == 0) return 0;
        dm = d < 0 ? -d : d;
        tt = longint'(thresh) * longint'(thresh);
        // squared z-score test, exact in wide integers
        if (w >= 2 && q >= ww * (ww - 1)) begin
          m1 = dm * dm; m2 = 65536 * (ww - 1);
          lhs = m1 * m2;
          m1 = tt; m2 = ww * q;
          rhs = m1 * m2;
        end else begin
          m1 = dm * dm; m2 = 65536;
          lhs = m1 * m2;
          m1 = tt; m2 = ww * ww;
          rhs = m1 * m2;
        end
        if (!(lhs > rhs)) return 0;
        return d > 0 ? -1 : 1;
      end
      tspe_pkg::MODE_IMBALANCE: begin
        if (seen < w) return 0;
        bal = 0; cur = p;
        for (int k = 0; k < w; k++) begin
          bal += (cur >= longint'(hist[k])) ? 1 : -1;
          cur = hist[k];
        end
        bal *= 256;
        t *= w;
        return bal > t ? 1 : (bal < -t ? -1 : 0);
      end
      default: begin
        last = hist[0];
        mv = p - last;
        if (mv < 0) mv = -mv;
        absinv = inv < 0 ? -inv : inv;
        if (!(absinv < longint'(maxinv) && mv * 256 >= longint'(spread))) return 0;
        sig = p > last ? -1 : 1;
        if (inv > 0) sig -= skew;
        if (inv < 0) sig += skew;
        return sig > 0 ? 1 : (sig < 0 ? -1 : 0);
      end
    endcase
  endfunction

  // accepted input transfer: advance state, queue the expected result
  function void note_price(bit start, logic [15:0] price);
    longint p, q, nv, pnl, dd, hi;
    int w, sig;
    logic [1:0] sbits;
    p = price;
    q = qty;
    hi = 64'h7FFF_FFFF_FFFF;
    if (start) clear();
    if (seen == 0) begin
      hist[0] = price;
      seen = 1;
      return;
    end
    w = wlen;
    if (w == 0) w = 1;
    sig = decide(p, w);
    if (sig != 0) begin
      nv = inv + (sig > 0 ? q : -q);
      if (nv > 64'sd2147483647) nv = 64'sd2147483647;
      if (nv < -64'sd2147483648) nv = -64'sd2147483648;
      inv = nv;
      if (sig > 0) cash = clamp48(cash - p * q * 100 - 3 * q);
      else cash = clamp48(cash + p * q * 100 - 3 * q);
      trades = sat32(trades + 1);
      volume = sat32(volume + q);
    end
    pnl = clamp48(cash + inv * p * 100);
    if (pnl > peak) peak = pnl;
    dd = peak - pnl;
    if (dd > hi) dd = hi;
    if (dd > worst) worst = dd;
    if (inv != 0) expo = sat32(expo + 1);
    for (int k = 15; k > 0; k--) hist[k] = hist[k-1];
    hist[0] = price;
    if (seen < 31) seen++;
    signals[sig + 1]++;
    sbits = sig > 0 ? tspe_pkg::SIG_BUY : (sig < 0 ? tspe_pkg::SIG_SELL : tspe_pkg::SIG_NONE);
    expected_q.insert(expected_q.size(),
                      {expo[31:0], volume[31:0], trades[31:0], worst[46:0], dd[46:0],
                       pnl[47:0], inv[31:0], sbits});
  endfunction

  function void cmp(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // accepted result transfer
  function void check_result(logic [271:0] act);
    logic [271:0] e;
    results++;
    if (expected_q.size() == 0) begin
      $error("result with no expectation pending: 0x%0h", act);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    cmp("trade_signal",       e[1:0],     act[1:0]);
    cmp("inventory",          e[33:2],    act[33:2]);
    cmp("pnl_cents",          e[81:34],   act[81:34]);
    cmp("drawdown_cents",     e[128:82],  act[128:82]);
    cmp("max_drawdown_cents", e[175:129], act[175:129]);
    cmp("trade_count",        e[207:176], act[207:176]);
    cmp("traded_volume",      e[239:208], act[239:208]);
    cmp("exposure_ticks",     e[271:240], act[271:240]);
  endfunction
endclass

module testbench;
  import tspe_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 60;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [23:0]  in_tdata;   // [0] series_start, [16:1] price, [23:17] zero
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [271:0] out_tdata;  // signal, inventory, pnl, drawdown, max drawdown,
                            // trade count, volume, exposure (low bits up)
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [15:0]  cfg_data;

  pnl_scoreboard sb;
  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_req;        // bumped by stimulus to ask for a long receiver hold-off
  int  hold_seen = 0;
  int  hold_left = 0;
  int  items_sent;
  int  cycles = 0;
  logic [15:0] walk_price;

  trading_signal_pnl_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Timeout watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench: errors");
      $finish;
    end
  end

  // Receiver: random stalls, long hold-off on request, result check
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 400;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // One input transfer; valid stays high unless the sender idles first
  task automatic send_price(bit start, logic [15:0] price);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, price, start};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_price(start, price);
    items_sent++;
  endtask

  // Register write; caller drops cfg_valid after a burst
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic write_all(logic [1:0] m, logic [3:0] w, logic [15:0] t, logic [7:0] q,
                           logic [15:0] s, logic [2:0] k, logic [15:0] mi);
    write_reg(REG_MODE, {14'd0, m});
    write_reg(REG_WINDOW, {12'd0, w});
    write_reg(REG_THRESHOLD, t);
    write_reg(REG_ORDER, {8'd0, q});
    write_reg(REG_SPREAD, s);
    write_reg(REG_SKEW, {13'd0, k});
    write_reg(REG_MAX_INV, mi);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every expected result is back, then let the engine settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Next price of a random walk, with occasional jumps and extremes
  function automatic logic [15:0] next_price(int stepmax);
    int v, r;
    r = $urandom_range(99);
    if (r < 3) return 16'hFFFF;
    if (r < 5) return 16'h0000;
    if (r < 10) return 16'($urandom_range(65535));
    v = int'(walk_price) + $urandom_range(2 * stepmax) - stepmax;
    if (v < 1) v = 1;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  initial begin
    int m, w, q, sk, stepmax, nseries;
    logic [15:0] t, s, mi;
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 0;
    items_sent = 0;
    walk_price = 16'd1000;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset defaults, price extremes, zero price, mid-series restart
    send_price(1'b1, 16'd1);
    send_price(1'b0, 16'hFFFF);
    send_price(1'b0, 16'd0);
    send_price(1'b0, 16'h8000);
    send_price(1'b0, 16'h7FFF);
    send_price(1'b0, 16'd2);
    send_price(1'b0, 16'hFFFF);
    send_price(1'b1, 16'd500);
    send_price(1'b0, 16'd600);
    drain();
    // window of zero acts as one; widest window; zero and full thresholds
    write_all(MODE_MEAN_REV, 4'd0, 16'd0, 8'd255, 16'd0, 3'd7, 16'd0);
    send_price(1'b1, 16'd100);
    send_price(1'b0, 16'd100);
    send_price(1'b0, 16'd101);
    send_price(1'b0, 16'hFFFF);
    send_price(1'b0, 16'd0);
    drain();
    write_all(MODE_MKT_MAKE, 4'd15, 16'hFFFF, 8'd255, 16'd0, 3'd7, 16'hFFFF);
    send_price(1'b1, 16'd300);
    for (int i = 0; i < 8; i++) send_price(1'b0, (i % 2) ? 16'd200 : 16'hFFFF);
    drain();

    // Random phases: one register setting each, several series
    for (int ph = 0; ph < 24; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      m  = ph % 4;
      w  = (ph < 8) ? ((ph % 3 == 0) ? 1 : 15) : $urandom_range(15);
      q  = (ph % 5 == 0) ? 255 : $urandom_range(1, 20);
      sk = $urandom_range(7);
      case ($urandom_range(3))
        0: t = 16'd0;
        1: t = 16'hFFFF;
        default: t = 16'($urandom_range(m == MODE_MEAN_REV ? 768 : 2048));
      endcase
      s  = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom_range(2048));
      mi = ($urandom_range(4) == 0) ? 16'hFFFF : 16'($urandom_range(40));
      write_all(m[1:0], w[3:0], t, q[7:0], s, sk[2:0], mi);
      if (ph == 2) hold_req = hold_req + 1;
      stepmax = $urandom_range(1, 3) * 4 * $urandom_range(1, 50);
      nseries = $urandom_range(1, 3);
      for (int sn = 0; sn < nseries; sn++) begin
        walk_price = 16'($urandom_range(1, 65535));
        send_price(1'b1, walk_price);
        for (int i = 0; i < 31 / nseries; i++) begin
          walk_price = next_price(stepmax);
          send_price($urandom_range(99) < 2, walk_price);
        end
      end
      drain();
    end

    $display("ran %0d prices, %0d results checked (buys %0d, sells %0d, holds %0d)",
             items_sent, sb.results, sb.signals[2], sb.signals[0], sb.signals[1]);
    $display("all four strategies under several register settings and handshake loads");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
